// ===== hw/rtl/touch_affine_calibration_defines.svh =====
// Assertion macros shared by the touch calibration RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef TOUCH_AFFINE_CALIBRATION_DEFINES_SVH
`define TOUCH_AFFINE_CALIBRATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define TAC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TAC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAC_ASSERT(label, clk, rst, prop, msg)
`define TAC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/tac_pkg.sv =====
// Shared types and constants of the touch calibration block.
// No dependencies; used by the serial MAC, the divider and the top level.
package tac_pkg;

   localparam int CoefBits  = 32;
   localparam int AccBits   = 48;
   localparam int DigitBits = 12;
   localparam int RawBits   = 10;
   localparam int TgtBits   = 8;
   localparam int ScrBits   = 16;
   localparam int NumTgtRegs = 6;
   localparam int IdxBits   = 3;

   localparam logic [TgtBits-1:0] TargetReset [NumTgtRegs] =
      '{8'd24, 8'd13, 8'd120, 8'd114, 8'd215, 8'd63};

   localparam logic [AccBits-1:0] SatPos = 48'd32767;
   localparam logic [AccBits-1:0] SatNeg = 48'd32768;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic neg;
   } mac_ctl_type;

endpackage

// ===== hw/rtl/tac_mac.sv =====
// Bit-serial multiply-accumulate: acc = acc_init + p * q (minus when ctl.neg), one bit of q per cycle.
// Depends on tac_pkg.
module tac_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tac_pkg::mac_ctl_type                 ctl,
   input  logic signed [tac_pkg::CoefBits-1:0]  p,
   input  logic [tac_pkg::DigitBits-1:0]        q,
   input  logic [tac_pkg::AccBits-1:0]          acc_init,
   output logic                                 done,
   output logic [tac_pkg::AccBits-1:0]          acc
);
   localparam int CntBits = $clog2(tac_pkg::DigitBits);
   localparam logic [CntBits-1:0] CntLast = CntBits'(tac_pkg::DigitBits - 1);

   logic                        run_ff, run_in, done_ff, done_in;
   logic [CntBits-1:0]          cnt_ff, cnt_in;
   logic [tac_pkg::AccBits-1:0] acc_ff, acc_in, psh_ff, psh_in, p_ext;
   logic [tac_pkg::DigitBits-1:0] q_ff, q_in;

   assign p_ext = {{(tac_pkg::AccBits - tac_pkg::CoefBits){p[tac_pkg::CoefBits-1]}}, p};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      psh_in  = psh_ff;
      q_in    = q_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         acc_in = acc_init;
         psh_in = ctl.neg ? -p_ext : p_ext;
         q_in   = q;
      end else if (run_ff) begin
         // top bit of q carries negative weight
         if (q_ff[0]) begin
            acc_in = (cnt_ff == CntLast) ? acc_ff - psh_ff : acc_ff + psh_ff;
         end
         psh_in = {psh_ff[tac_pkg::AccBits-2:0], 1'b0};
         q_in   = {1'b0, q_ff[tac_pkg::DigitBits-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      psh_ff <= psh_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
endmodule

// ===== hw/rtl/tac_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero,
// result saturated to signed 16 bits. Depends on tac_pkg.
module tac_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [tac_pkg::AccBits-1:0]          num,
   input  logic [tac_pkg::CoefBits-1:0]         den,
   output logic                                 done,
   output logic [tac_pkg::ScrBits-1:0]          result
);
   localparam int CntBits = $clog2(tac_pkg::AccBits);
   localparam logic [CntBits-1:0] CntLast = CntBits'(tac_pkg::AccBits - 1);

   logic                          run_ff, run_in, fin_ff, fin_in, done_ff, done_in;
   logic                          neg_ff, neg_in, zero_ff, zero_in;
   logic [CntBits-1:0]            cnt_ff, cnt_in;
   logic [tac_pkg::AccBits-1:0]   mag_ff, mag_in, quo_ff, quo_in;
   logic [tac_pkg::CoefBits:0]    rem_ff, rem_in, rem_sh;
   logic [tac_pkg::CoefBits-1:0]  den_ff, den_in;
   logic [tac_pkg::ScrBits-1:0]   res_ff, res_in;

   assign rem_sh = {rem_ff[tac_pkg::CoefBits-1:0], mag_ff[tac_pkg::AccBits-1]};

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = '0;
         neg_in  = num[tac_pkg::AccBits-1] ^ den[tac_pkg::CoefBits-1];
         zero_in = (den == '0);
         mag_in  = num[tac_pkg::AccBits-1] ? -num : num;
         den_in  = den[tac_pkg::CoefBits-1] ? -den : den;
      end else if (run_ff) begin
         mag_in = {mag_ff[tac_pkg::AccBits-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[tac_pkg::AccBits-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[tac_pkg::AccBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         // sign and clamp the magnitude
         done_in = 1'b1;
         priority if (zero_ff) begin
            res_in = '0;
         end else if (!neg_ff) begin
            res_in = (quo_ff > tac_pkg::SatPos) ? 16'h7fff : quo_ff[tac_pkg::ScrBits-1:0];
         end else begin
            res_in = (quo_ff > tac_pkg::SatNeg) ? 16'h8000 : -quo_ff[tac_pkg::ScrBits-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

// ===== hw/rtl/touch_affine_calibration.sv =====
// Touch calibration: a word without coordinates or an early capture goes straight to the response state.
// A mapped sample runs 4 serial MAC passes (one bit of x or y per cycle) and 2 divides (one
// quotient bit per cycle); the third capture runs 16 MAC passes for the fit.
// One word at a time; the next is taken while the finished result waits on rsp.
// Synchronous reset restores identity coefficients, default targets and clears the drag flag.
`include "touch_affine_calibration_defines.svh"
module touch_affine_calibration (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // raw_x[9:0], raw_y[19:10], zero pad
   input  logic [1:0]  req_tuser,   // cmd[0], coord_flag[1]
   input  logic        req_tlast,   // end_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // screen_x[15:0], screen_y[31:16], dragging[32], zero pad
   output logic [2:0]  rsp_tuser,   // point_valid[0], calib_done[1], calib_accepted[2]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   localparam int CB = tac_pkg::CoefBits;
   localparam int AB = tac_pkg::AccBits;
   localparam int DB = tac_pkg::DigitBits;
   localparam int RB = tac_pkg::RawBits;
   localparam int SB = tac_pkg::ScrBits;

   // micro-op numbers: mapping passes first, then the fit
   localparam logic [4:0] OpMapFirst = 5'd0;
   localparam logic [4:0] OpMapLast  = 5'd3;
   localparam logic [4:0] OpFitFirst = 5'd4;
   localparam logic [4:0] OpFitLast  = 5'd19;

   typedef enum logic [1:0] {INIT_ZERO, INIT_KEEP, INIT_C, INIT_F} init_type;
   typedef enum logic [3:0] {
      DST_NONE, DST_NX, DST_NY, DST_NK, DST_NA, DST_NB, DST_NC, DST_ND, DST_NE, DST_NF
   } dest_type;

   tac_pkg::state_type state_ff, state_in;

   logic [tac_pkg::TgtBits-1:0] tgt_ff [tac_pkg::NumTgtRegs];
   logic [RB-1:0]  cap_x_ff [3];
   logic [RB-1:0]  cap_y_ff [3];
   logic [1:0]     cap_idx_ff;
   logic           drag_ff;
   logic [CB-1:0]  coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff, coef_e_ff, coef_f_ff;
   logic [CB-1:0]  divisor_ff;
   logic [CB-1:0]  nk_ff, na_ff, nb_ff, nc_ff, nd_ff, ne_ff;
   logic [AB-1:0]  nx_ff, ny_ff;
   logic [RB-1:0]  in_x_ff, in_y_ff;
   logic [4:0]     op_ff, op_in;
   logic           mac_go_ff, mac_go_in, div_go_ff, div_go_in, div_sel_ff, div_sel_in;
   logic [SB-1:0]  res_x_ff, res_y_ff;
   logic           res_valid_ff, res_done_ff, res_acc_ff;
   logic           rsp_valid_ff;
   logic [39:0]    rsp_data_ff;
   logic [2:0]     rsp_user_ff;

   logic           accept, load_rsp, mac_done, div_done;
   logic [AB-1:0]  mac_acc, acc_init;
   logic [SB-1:0]  div_res;
   logic signed [CB-1:0] op_p;
   logic [DB-1:0]  op_q;
   logic           op_neg;
   init_type       op_init;
   dest_type       op_dest;
   tac_pkg::mac_ctl_type mac_ctl;

   logic [RB-1:0]  raw_x, raw_y;
   logic           cmd, coord, endf;

   assign raw_x = req_tdata[RB-1:0];
   assign raw_y = req_tdata[2*RB-1:RB];
   assign cmd   = req_tuser[0];
   assign coord = req_tuser[1];
   assign endf  = req_tlast;

   assign req_tready = (state_ff == tac_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == tac_pkg::ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // differences of captured points and targets, all fit in the 12-bit digit
   logic signed [DB-1:0] dtx0, dtx1, dty0, dty1, ddx0, ddx1, ddy0, ddy1;
   logic [DB-1:0] tx2q, ty2q, dx2q, dy2q, xq, yq;
   assign dtx0 = {2'b00, cap_x_ff[0]} - {2'b00, cap_x_ff[2]};
   assign dtx1 = {2'b00, cap_x_ff[1]} - {2'b00, cap_x_ff[2]};
   assign dty0 = {2'b00, cap_y_ff[0]} - {2'b00, cap_y_ff[2]};
   assign dty1 = {2'b00, cap_y_ff[1]} - {2'b00, cap_y_ff[2]};
   assign ddx0 = {4'h0, tgt_ff[0]} - {4'h0, tgt_ff[4]};
   assign ddx1 = {4'h0, tgt_ff[2]} - {4'h0, tgt_ff[4]};
   assign ddy0 = {4'h0, tgt_ff[1]} - {4'h0, tgt_ff[5]};
   assign ddy1 = {4'h0, tgt_ff[3]} - {4'h0, tgt_ff[5]};
   assign tx2q = {2'b00, cap_x_ff[2]};
   assign ty2q = {2'b00, cap_y_ff[2]};
   assign dx2q = {4'h0, tgt_ff[4]};
   assign dy2q = {4'h0, tgt_ff[5]};
   assign xq   = {2'b00, in_x_ff};
   assign yq   = {2'b00, in_y_ff};

   function automatic logic [CB-1:0] sx12(input logic [DB-1:0] v);
      sx12 = {{(CB - DB){v[DB-1]}}, v};
   endfunction

   // Micro-program. Fit: K, then A B D E by 2x2 determinants, then
   // C = K*x2' - A*x2 - B*y2 and F = K*y2' - D*x2 - E*y2, which equal the
   // three-point formulas since the fitted map hits the third target exactly.
   always_comb begin
      op_p    = '0;
      op_q    = '0;
      op_neg  = 1'b0;
      op_init = INIT_ZERO;
      op_dest = DST_NONE;
      unique case (op_ff)
         5'd0:  begin op_p = coef_a_ff; op_q = xq; op_init = INIT_C; end
         5'd1:  begin op_p = coef_b_ff; op_q = yq; op_init = INIT_KEEP; op_dest = DST_NX; end
         5'd2:  begin op_p = coef_d_ff; op_q = xq; op_init = INIT_F; end
         5'd3:  begin op_p = coef_e_ff; op_q = yq; op_init = INIT_KEEP; op_dest = DST_NY; end
         5'd4:  begin op_p = sx12(dtx0); op_q = dty1; end
         5'd5:  begin
            op_p = sx12(dtx1); op_q = dty0; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_NK;
         end
         5'd6:  begin op_p = sx12(ddx0); op_q = dty1; end
         5'd7:  begin
            op_p = sx12(ddx1); op_q = dty0; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_NA;
         end
         5'd8:  begin op_p = sx12(dtx0); op_q = ddx1; end
         5'd9:  begin
            op_p = sx12(dtx1); op_q = ddx0; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_NB;
         end
         5'd10: begin op_p = sx12(ddy0); op_q = dty1; end
         5'd11: begin
            op_p = sx12(ddy1); op_q = dty0; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_ND;
         end
         5'd12: begin op_p = sx12(dtx0); op_q = ddy1; end
         5'd13: begin
            op_p = sx12(dtx1); op_q = ddy0; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_NE;
         end
         5'd14: begin op_p = nk_ff; op_q = dx2q; end
         5'd15: begin op_p = na_ff; op_q = tx2q; op_neg = 1'b1; op_init = INIT_KEEP; end
         5'd16: begin
            op_p = nb_ff; op_q = ty2q; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_NC;
         end
         5'd17: begin op_p = nk_ff; op_q = dy2q; end
         5'd18: begin op_p = nd_ff; op_q = tx2q; op_neg = 1'b1; op_init = INIT_KEEP; end
         5'd19: begin
            op_p = ne_ff; op_q = ty2q; op_neg = 1'b1; op_init = INIT_KEEP;
            op_dest = DST_NF;
         end
         default: begin op_p = '0; end
      endcase
   end

   always_comb begin
      unique case (op_init)
         INIT_ZERO: acc_init = '0;
         INIT_KEEP: acc_init = mac_acc;
         INIT_C:    acc_init = {{(AB - CB){coef_c_ff[CB-1]}}, coef_c_ff};
         INIT_F:    acc_init = {{(AB - CB){coef_f_ff[CB-1]}}, coef_f_ff};
         default:   acc_init = '0;
      endcase
   end

   assign mac_ctl.start = mac_go_ff;
   assign mac_ctl.neg   = op_neg;

   tac_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .p        (op_p),
      .q        (op_q),
      .acc_init (acc_init),
      .done     (mac_done),
      .acc      (mac_acc)
   );

   tac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_go_ff),
      .num    (div_sel_ff ? ny_ff : nx_ff),
      .den    (divisor_ff),
      .done   (div_done),
      .result (div_res)
   );

   // sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      mac_go_in  = 1'b0;
      div_go_in  = 1'b0;
      div_sel_in = div_sel_ff;
      unique case (state_ff)
         tac_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (!cmd && coord) begin
                  state_in  = tac_pkg::ST_MAC;
                  op_in     = OpMapFirst;
                  mac_go_in = 1'b1;
               end else if (cmd && cap_idx_ff == 2'd2) begin
                  state_in  = tac_pkg::ST_MAC;
                  op_in     = OpFitFirst;
                  mac_go_in = 1'b1;
               end else begin
                  state_in = tac_pkg::ST_RESP;
               end
            end
         end
         tac_pkg::ST_MAC: begin
            if (mac_done) begin
               priority if (op_ff == OpMapLast) begin
                  state_in   = tac_pkg::ST_DIV;
                  div_go_in  = 1'b1;
                  div_sel_in = 1'b0;
               end else if (op_ff == OpFitLast) begin
                  state_in = tac_pkg::ST_RESP;
               end else begin
                  op_in     = op_ff + 1'b1;
                  mac_go_in = 1'b1;
               end
            end
         end
         tac_pkg::ST_DIV: begin
            if (div_done) begin
               if (!div_sel_ff) begin
                  div_sel_in = 1'b1;
                  div_go_in  = 1'b1;
               end else begin
                  state_in = tac_pkg::ST_RESP;
               end
            end
         end
         tac_pkg::ST_RESP: begin
            if (load_rsp) state_in = tac_pkg::ST_IDLE;
         end
         default: state_in = tac_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tac_pkg::ST_IDLE;
         op_ff      <= '0;
         mac_go_ff  <= 1'b0;
         div_go_ff  <= 1'b0;
         div_sel_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         mac_go_ff  <= mac_go_in;
         div_go_ff  <= div_go_in;
         div_sel_ff <= div_sel_in;
      end
   end

   // architectural state: targets, drag flag, capture index, coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tac_pkg::NumTgtRegs; i++) tgt_ff[i] <= tac_pkg::TargetReset[i];
         drag_ff    <= 1'b0;
         cap_idx_ff <= 2'd0;
         coef_a_ff  <= 32'd1;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         coef_d_ff  <= '0;
         coef_e_ff  <= 32'd1;
         coef_f_ff  <= '0;
         divisor_ff <= 32'd1;
      end else begin
         // drop writes past the last target register
         if (csr_we && csr_index < tac_pkg::IdxBits'(tac_pkg::NumTgtRegs)) begin
            tgt_ff[csr_index] <= csr_wdata;
         end
         if (accept) begin
            if (!cmd) begin
               priority if (endf) drag_ff <= 1'b0;
               else if (coord)    drag_ff <= 1'b1;
            end else begin
               cap_idx_ff <= (cap_idx_ff == 2'd2) ? 2'd0 : cap_idx_ff + 2'd1;
            end
         end
         // commit the fit only with a nonzero determinant
         if (state_ff == tac_pkg::ST_MAC && mac_done && op_ff == OpFitLast && nk_ff != '0) begin
            coef_a_ff  <= na_ff;
            coef_b_ff  <= nb_ff;
            coef_c_ff  <= nc_ff;
            coef_d_ff  <= nd_ff;
            coef_e_ff  <= ne_ff;
            coef_f_ff  <= mac_acc[CB-1:0];
            divisor_ff <= nk_ff;
         end
      end
   end

   // payload: captures, operands, partial results
   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff <= raw_x;
         in_y_ff <= raw_y;
         if (cmd) begin
            cap_x_ff[cap_idx_ff] <= raw_x;
            cap_y_ff[cap_idx_ff] <= raw_y;
         end
         res_x_ff     <= '0;
         res_y_ff     <= '0;
         res_valid_ff <= !cmd && coord;
         res_done_ff  <= cmd && cap_idx_ff == 2'd2;
         res_acc_ff   <= 1'b0;
      end
      if (state_ff == tac_pkg::ST_MAC && mac_done) begin
         unique case (op_dest)
            DST_NX:   nx_ff <= mac_acc;
            DST_NY:   ny_ff <= mac_acc;
            DST_NK:   nk_ff <= mac_acc[CB-1:0];
            DST_NA:   na_ff <= mac_acc[CB-1:0];
            DST_NB:   nb_ff <= mac_acc[CB-1:0];
            DST_NC:   nc_ff <= mac_acc[CB-1:0];
            DST_ND:   nd_ff <= mac_acc[CB-1:0];
            DST_NE:   ne_ff <= mac_acc[CB-1:0];
            DST_NF:   res_acc_ff <= (nk_ff != '0);
            default:  ;
         endcase
      end
      if (state_ff == tac_pkg::ST_DIV && div_done) begin
         if (div_sel_ff) res_y_ff <= div_res;
         else            res_x_ff <= div_res;
      end
      if (load_rsp) begin
         rsp_data_ff <= {7'd0, drag_ff, res_y_ff, res_x_ff};
         rsp_user_ff <= {res_acc_ff, res_done_ff, res_valid_ff};
      end
   end

   // output register: hold the word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `TAC_ASSERT_ALWAYS(a_reset_empties_rsp, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
   `TAC_ASSERT(a_divisor_nonzero, clock, reset, divisor_ff != '0, "zero divisor stored")
   `TAC_ASSERT(a_acc_needs_done, clock, reset, rsp_tvalid |-> !(rsp_tuser[2] && !rsp_tuser[1]), "accepted without done")
   `TAC_ASSERT(a_point_or_calib, clock, reset, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]), "point and calib in one word")
   `TAC_ASSERT(a_one_at_a_time, clock, reset, accept |=> !req_tready, "second word taken while busy")
   `TAC_ASSERT(a_capture_index, clock, reset, cap_idx_ff != 2'd3, "capture index out of range")
endmodule

// ===== tb/touch_affine_calibration_tb.sv =====
// Testbench for touch_affine_calibration: directed and random stream traffic, an in-bench
// predictor of the calibration fit and mapping, and a field-by-field result check.
// Depends on tac_pkg and the touch_affine_calibration RTL.
module touch_affine_calibration_tb;

   typedef enum logic {
      CMD_SAMPLE  = 1'b0,
      CMD_CAPTURE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      REG_TX0 = 3'd0,
      REG_TY0 = 3'd1,
      REG_TX1 = 3'd2,
      REG_TY1 = 3'd3,
      REG_TX2 = 3'd4,
      REG_TY2 = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               point_valid;
      logic               dragging;
      logic               calib_done;
      logic               calib_accepted;
   } touch_result_type;

   localparam int StallLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // raw_x[9:0], raw_y[19:10], zero pad
   logic [1:0]  req_tuser = '0;   // cmd[0], coord_flag[1]
   logic        req_tlast = 1'b0; // end_flag
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // screen_x[15:0], screen_y[31:16], dragging[32]
   logic [2:0]  rsp_tuser;        // point_valid[0], calib_done[1], calib_accepted[2]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   touch_affine_calibration dut (.*);

   always #4 clock = ~clock;

   // predictor state
   logic [7:0]         targets [tac_pkg::NumTgtRegs];
   logic               drag_now;
   longint             cf_a, cf_b, cf_c, cf_d, cf_e, cf_f, cf_k;
   longint             cap_x [3];
   longint             cap_y [3];
   int                 cap_idx;
   touch_result_type   expected_points [$];
   bit                 failed = 1'b0;
   int                 idle_cycles = 0;
   int                 stall_max = 3;

   function automatic logic [15:0] map_coord(longint num, longint den);
      longint q;
      if (den == 0) return 16'd0;
      q = num / den;   // truncates toward zero
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic longint wrap32(longint v);
      logic signed [31:0] t;
      t = v[31:0];
      return longint'(t);
   endfunction

   // Solve the three-point affine fit from the captured raw points.
   task automatic run_fit(output bit ok);
      longint tx0, ty0, tx1, ty1, tx2, ty2, dx0, dy0, dx1, dy1, dx2, dy2, k;
      tx0 = cap_x[0]; ty0 = cap_y[0]; tx1 = cap_x[1]; ty1 = cap_y[1];
      tx2 = cap_x[2]; ty2 = cap_y[2];
      dx0 = longint'(targets[0]); dy0 = longint'(targets[1]); dx1 = longint'(targets[2]);
      dy1 = longint'(targets[3]); dx2 = longint'(targets[4]); dy2 = longint'(targets[5]);
      k = (tx0 - tx2) * (ty1 - ty2) - (tx1 - tx2) * (ty0 - ty2);
      ok = (k != 0);
      if (!ok) return;
      cf_a = wrap32((dx0 - dx2) * (ty1 - ty2) - (dx1 - dx2) * (ty0 - ty2));
      cf_b = wrap32((tx0 - tx2) * (dx1 - dx2) - (dx0 - dx2) * (tx1 - tx2));
      cf_c = wrap32((tx2 * dx1 - tx1 * dx2) * ty0 + (tx0 * dx2 - tx2 * dx0) * ty1
                    + (tx1 * dx0 - tx0 * dx1) * ty2);
      cf_d = wrap32((dy0 - dy2) * (ty1 - ty2) - (dy1 - dy2) * (ty0 - ty2));
      cf_e = wrap32((tx0 - tx2) * (dy1 - dy2) - (dy0 - dy2) * (tx1 - tx2));
      cf_f = wrap32((tx2 * dy1 - tx1 * dy2) * ty0 + (tx0 * dy2 - tx2 * dy0) * ty1
                    + (tx1 * dy0 - tx0 * dy1) * ty2);
      cf_k = wrap32(k);
   endtask

   task automatic predict_word(cmd_type cmd, logic [9:0] x, logic [9:0] y,
                               logic coord, logic endf);
      touch_result_type r;
      bit ok;
      longint xl, yl;
      r = '0;
      xl = longint'(x);
      yl = longint'(y);
      if (cmd == CMD_SAMPLE) begin
         if (endf) drag_now = 1'b0;
         else if (coord) drag_now = 1'b1;
         if (coord) begin
            r.screen_x = map_coord(cf_a * xl + cf_b * yl + cf_c, cf_k);
            r.screen_y = map_coord(cf_d * xl + cf_e * yl + cf_f, cf_k);
            r.point_valid = 1'b1;
         end
      end else begin
         cap_x[cap_idx] = xl;
         cap_y[cap_idx] = yl;
         if (cap_idx == 2) begin
            run_fit(ok);
            r.calib_done = 1'b1;
            r.calib_accepted = ok;
            cap_idx = 0;
         end else begin
            cap_idx++;
         end
      end
      r.dragging = drag_now;
      expected_points.push_back(r);
   endtask

   // Present one word, hold it until accepted, then drop valid for a random gap, or keep it up when the gap is zero.
   task automatic send_word(cmd_type cmd, logic [9:0] x, logic [9:0] y,
                            logic coord, logic endf);
      int gap;
      req_tdata  <= {4'd0, y, x};
      req_tuser  <= {coord, cmd};
      req_tlast  <= endf;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(cmd, x, y, coord, endf);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);   // extra idle time before any write
   endtask

   task automatic write_target(reg_index_type idx, logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      targets[idx] = val;
      @(posedge clock);
   endtask

   task automatic write_all_targets(logic [7:0] v0, v1, v2, v3, v4, v5);
      write_target(REG_TX0, v0); write_target(REG_TY0, v1);
      write_target(REG_TX1, v2); write_target(REG_TY1, v3);
      write_target(REG_TX2, v4); write_target(REG_TY2, v5);
   endtask

   task automatic send_calibration(logic [9:0] x0, y0, x1, y1, x2, y2);
      send_word(CMD_CAPTURE, x0, y0, 1'($urandom), 1'($urandom));
      send_word(CMD_CAPTURE, x1, y1, 1'($urandom), 1'($urandom));
      send_word(CMD_CAPTURE, x2, y2, 1'($urandom), 1'($urandom));
   endtask

   // Directed: identity mapping extremes, flag combinations, degenerate and good fits.
   task automatic test_directed();
      send_word(CMD_SAMPLE, 10'd0, 10'd0, 1'b1, 1'b0);
      send_word(CMD_SAMPLE, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
      send_word(CMD_SAMPLE, 10'h155, 10'h2AA, 1'b0, 1'b0);
      send_word(CMD_SAMPLE, 10'h2AA, 10'h155, 1'b1, 1'b1);
      send_word(CMD_SAMPLE, 10'd5, 10'd7, 1'b0, 1'b1);
      // collinear points: zero divisor, fit rejected
      send_calibration(10'd100, 10'd100, 10'd200, 10'd200, 10'd300, 10'd300);
      send_word(CMD_SAMPLE, 10'd300, 10'd400, 1'b1, 1'b0);
      send_calibration(10'd100, 10'd100, 10'd900, 10'd500, 10'd500, 10'd900);
      send_word(CMD_SAMPLE, 10'd0, 10'd0, 1'b1, 1'b0);
      send_word(CMD_SAMPLE, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
      send_word(CMD_SAMPLE, 10'h3FF, 10'd0, 1'b1, 1'b0);
      // steep fit drives saturation on both ends
      send_calibration(10'd500, 10'd500, 10'd501, 10'd500, 10'd500, 10'd501);
      send_word(CMD_SAMPLE, 10'd0, 10'd0, 1'b1, 1'b0);
      send_word(CMD_SAMPLE, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
      send_word(CMD_SAMPLE, 10'd0, 10'h3FF, 1'b1, 1'b1);
      drain_results();
   endtask

   // Extreme and mixed targets, each followed by a fit; the first two also by one sample.
   task automatic test_target_settings();
      write_all_targets(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_calibration(10'd10, 10'd20, 10'd1000, 10'd30, 10'd40, 10'd1010);
      send_word(CMD_SAMPLE, 10'd512, 10'd512, 1'b1, 1'b0);
      drain_results();
      write_all_targets(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_calibration(10'd0, 10'd0, 10'h3FF, 10'd0, 10'd0, 10'h3FF);
      send_word(CMD_SAMPLE, 10'd700, 10'd300, 1'b1, 1'b0);
      drain_results();
      write_all_targets(8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd128);
      send_calibration(10'd50, 10'd60, 10'd950, 10'd80, 10'd500, 10'd970);
      drain_results();
   endtask

   // Random traffic, mostly samples with whole calibration runs and lone captures mixed in.
   task automatic test_random(int words);
      int n;
      n = 0;
      while (n < words) begin
         if (n % 500 == 250) begin
            drain_results();   // pause until every pending result is back
            write_all_targets(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom));
            stall_max = (stall_max == 3) ? 30 : 3;
         end
         if ($urandom_range(0, 19) == 0) begin
            send_calibration(10'($urandom), 10'($urandom), 10'($urandom),
                             10'($urandom), 10'($urandom), 10'($urandom));
            n += 3;
         end else if ($urandom_range(0, 49) == 0) begin
            send_word(CMD_CAPTURE, 10'($urandom), 10'($urandom), 1'($urandom),
                      1'($urandom));
            n++;
         end else begin
            send_word(CMD_SAMPLE, 10'($urandom), 10'($urandom),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
            n++;
         end
      end
      drain_results();
   endtask

   // Result sink: random backpressure, bursts with none.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 10) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 5)
         rsp_tready <= ($urandom_range(0, stall_max) == 0);
      else rsp_tready <= 1'b1;
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      touch_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.screen_x       = rsp_tdata[15:0];
         got.screen_y       = rsp_tdata[31:16];
         got.dragging       = rsp_tdata[32];
         got.point_valid    = rsp_tuser[0];
         got.calib_done     = rsp_tuser[1];
         got.calib_accepted = rsp_tuser[2];
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            failed = 1'b1;
         end else begin
            want = expected_points.pop_front();
            if (got.screen_x !== want.screen_x)
               $display("%0t: screen_x expected %0d actual %0d", $time,
                        want.screen_x, got.screen_x);
            if (got.screen_y !== want.screen_y)
               $display("%0t: screen_y expected %0d actual %0d", $time,
                        want.screen_y, got.screen_y);
            if (got.point_valid !== want.point_valid)
               $display("%0t: point_valid expected %0b actual %0b", $time,
                        want.point_valid, got.point_valid);
            if (got.dragging !== want.dragging)
               $display("%0t: dragging expected %0b actual %0b", $time,
                        want.dragging, got.dragging);
            if (got.calib_done !== want.calib_done)
               $display("%0t: calib_done expected %0b actual %0b", $time,
                        want.calib_done, got.calib_done);
            if (got.calib_accepted !== want.calib_accepted)
               $display("%0t: calib_accepted expected %0b actual %0b", $time,
                        want.calib_accepted, got.calib_accepted);
            if (got !== want) failed = 1'b1;
         end
      end
   end

   // Watchdog: advance a counter on every cycle with no handshake and end the run once it passes StallLimit.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < tac_pkg::NumTgtRegs; i++) targets[i] = tac_pkg::TargetReset[i];
      drag_now = 1'b0;
      cf_a = 1; cf_b = 0; cf_c = 0; cf_d = 0; cf_e = 1; cf_f = 0; cf_k = 1;
      cap_idx = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (300) @(posedge clock);   // idle wait after reset before the first test
      test_directed();
      test_target_settings();
      test_random(2000);
      if (failed || expected_points.size() != 0) begin
         $display("Test completed with failures");
      end else begin
         $display("Test completed successfully");
      end
      $finish;
   end

endmodule
